>>> hw/rtl/jsu_pkg.sv
package jsu_pkg;

    // Decoder phase: what the next byte means
    typedef enum logic [2:0] {
        PH_WAIT,
        PH_BODY,
        PH_ESC,
        PH_HEX,
        PH_UTF
    } t_phase;

    // Result kinds
    localparam logic [1:0] KIND_CP    = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
    localparam logic [2:0] ERR_ESCAPE   = 3'd2;
    localparam logic [2:0] ERR_HEX      = 3'd3;
    localparam logic [2:0] ERR_LEAD     = 3'd4;
    localparam logic [2:0] ERR_CONT     = 3'd5;
    localparam logic [2:0] ERR_CONTROL  = 3'd6;
    localparam logic [2:0] ERR_NUL      = 3'd7;

    // Characters of interest
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam int CP_W = 21;

    typedef struct packed {
        t_phase          phase;
        logic [1:0]      remaining;
        logic [CP_W-1:0] accumulator;
    } t_state;

    typedef struct packed {
        logic            emit;
        logic [1:0]      kind;
        logic [CP_W-1:0] cp_value;
        logic [2:0]      error_code;
    } t_result;

    localparam t_state STATE_RESET = '{phase: PH_WAIT, remaining: 2'd0, accumulator: '0};

    // Returns {valid, value} for one hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] v;
        v = '0;
        if (b inside {[8'h30:8'h39]}) begin
            v = {1'b1, b[3:0]};
        end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            v = {1'b1, b[3:0] + 4'd9};
        end
        return v;
    endfunction

    function automatic logic is_control(input logic [CP_W-1:0] cp);
        return (cp <= 21'h1f) || (cp == 21'h7f);
    endfunction

endpackage

>>> hw/rtl/jsu_if.sv
interface jsu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface jsu_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [20:0] cp_value;
    logic [2:0]  error_code;

    modport source (output valid, output result_kind, output cp_value, output error_code,
                    input ready);
    modport sink (input valid, input result_kind, input cp_value, input error_code,
                  output ready);
endinterface

>>> hw/rtl/jsu_step.sv
module jsu_step (
    input  logic [7:0]       i_byte,
    input  jsu_pkg::t_state  i_state,
    output jsu_pkg::t_state  o_state,
    output jsu_pkg::t_result o_res
);

    logic [4:0]                 w_hex;
    logic [jsu_pkg::CP_W-1:0]   w_utf_acc;
    logic [jsu_pkg::CP_W-1:0]   w_hex_acc;
    logic [1:0]                 w_rem_dec;

    assign w_hex     = jsu_pkg::hex_digit(i_byte);
    assign w_utf_acc = {i_state.accumulator[jsu_pkg::CP_W-7:0], i_byte[5:0]};
    assign w_hex_acc = {i_state.accumulator[jsu_pkg::CP_W-5:0], w_hex[3:0]};
    assign w_rem_dec = i_state.remaining - 2'd1;

    always_comb begin
        o_state = i_state;
        o_res   = '0;
        case (i_state.phase)
            jsu_pkg::PH_BODY: begin
                if (i_byte == jsu_pkg::CH_QUOTE) begin
                    o_state.phase = jsu_pkg::PH_WAIT;
                    o_res.emit    = 1'b1;
                    o_res.kind    = jsu_pkg::KIND_CLOSE;
                end else if (i_byte == jsu_pkg::CH_BSLASH) begin
                    o_state.phase = jsu_pkg::PH_ESC;
                end else if (i_byte == jsu_pkg::CH_NUL) begin
                    o_state          = jsu_pkg::STATE_RESET;
                    o_res.emit       = 1'b1;
                    o_res.kind       = jsu_pkg::KIND_ERR;
                    o_res.error_code = jsu_pkg::ERR_NUL;
                end else if (!i_byte[7]) begin
                    o_res.emit = 1'b1;
                    if (jsu_pkg::is_control({13'd0, i_byte})) begin
                        o_state          = jsu_pkg::STATE_RESET;
                        o_res.kind       = jsu_pkg::KIND_ERR;
                        o_res.error_code = jsu_pkg::ERR_CONTROL;
                    end else begin
                        o_res.kind     = jsu_pkg::KIND_CP;
                        o_res.cp_value = {13'd0, i_byte};
                    end
                end else if (i_byte[7:5] == 3'b110) begin
                    o_state.phase       = jsu_pkg::PH_UTF;
                    o_state.remaining   = 2'd1;
                    o_state.accumulator = {16'd0, i_byte[4:0]};
                end else if (i_byte[7:4] == 4'b1110) begin
                    o_state.phase       = jsu_pkg::PH_UTF;
                    o_state.remaining   = 2'd2;
                    o_state.accumulator = {17'd0, i_byte[3:0]};
                end else if (i_byte[7:3] == 5'b11110) begin
                    o_state.phase       = jsu_pkg::PH_UTF;
                    o_state.remaining   = 2'd3;
                    o_state.accumulator = {18'd0, i_byte[2:0]};
                end else begin
                    o_state          = jsu_pkg::STATE_RESET;
                    o_res.emit       = 1'b1;
                    o_res.kind       = jsu_pkg::KIND_ERR;
                    o_res.error_code = jsu_pkg::ERR_LEAD;
                end
            end

            jsu_pkg::PH_UTF: begin
                if (i_byte == jsu_pkg::CH_NUL || i_byte[7:6] != 2'b10) begin
                    o_state          = jsu_pkg::STATE_RESET;
                    o_res.emit       = 1'b1;
                    o_res.kind       = jsu_pkg::KIND_ERR;
                    o_res.error_code = (i_byte == jsu_pkg::CH_NUL) ? jsu_pkg::ERR_NUL
                                                                   : jsu_pkg::ERR_CONT;
                end else if (w_rem_dec != 2'd0) begin
                    o_state.remaining   = w_rem_dec;
                    o_state.accumulator = w_utf_acc;
                end else begin
                    o_state       = jsu_pkg::STATE_RESET;
                    o_state.phase = jsu_pkg::PH_BODY;
                    o_res.emit    = 1'b1;
                    if (jsu_pkg::is_control(w_utf_acc)) begin
                        // overlong form of a control character
                        o_state          = jsu_pkg::STATE_RESET;
                        o_res.kind       = jsu_pkg::KIND_ERR;
                        o_res.error_code = jsu_pkg::ERR_CONTROL;
                    end else begin
                        o_res.kind     = jsu_pkg::KIND_CP;
                        o_res.cp_value = w_utf_acc;
                    end
                end
            end

            jsu_pkg::PH_ESC: begin
                o_state.phase = jsu_pkg::PH_BODY;
                o_res.emit    = 1'b1;
                o_res.kind    = jsu_pkg::KIND_CP;
                case (i_byte)
                    jsu_pkg::CH_QUOTE:  o_res.cp_value = {13'd0, jsu_pkg::CH_QUOTE};
                    jsu_pkg::CH_BSLASH: o_res.cp_value = {13'd0, jsu_pkg::CH_BSLASH};
                    jsu_pkg::CH_SLASH:  o_res.cp_value = {13'd0, jsu_pkg::CH_SLASH};
                    jsu_pkg::CH_B:      o_res.cp_value = 21'h08;
                    jsu_pkg::CH_F:      o_res.cp_value = 21'h0c;
                    jsu_pkg::CH_N:      o_res.cp_value = 21'h0a;
                    jsu_pkg::CH_R:      o_res.cp_value = 21'h0d;
                    jsu_pkg::CH_T:      o_res.cp_value = 21'h09;
                    jsu_pkg::CH_U: begin
                        o_state.phase       = jsu_pkg::PH_HEX;
                        o_state.remaining   = 2'd3;
                        o_state.accumulator = '0;
                        o_res.emit          = 1'b0;
                    end
                    jsu_pkg::CH_NUL: begin
                        o_state          = jsu_pkg::STATE_RESET;
                        o_res.kind       = jsu_pkg::KIND_ERR;
                        o_res.error_code = jsu_pkg::ERR_NUL;
                    end
                    default: begin
                        o_state          = jsu_pkg::STATE_RESET;
                        o_res.kind       = jsu_pkg::KIND_ERR;
                        o_res.error_code = jsu_pkg::ERR_ESCAPE;
                    end
                endcase
            end

            jsu_pkg::PH_HEX: begin
                if (i_byte == jsu_pkg::CH_NUL || !w_hex[4]) begin
                    o_state          = jsu_pkg::STATE_RESET;
                    o_res.emit       = 1'b1;
                    o_res.kind       = jsu_pkg::KIND_ERR;
                    o_res.error_code = (i_byte == jsu_pkg::CH_NUL) ? jsu_pkg::ERR_NUL
                                                                   : jsu_pkg::ERR_HEX;
                end else if (i_state.remaining != 2'd0) begin
                    o_state.remaining   = w_rem_dec;
                    o_state.accumulator = w_hex_acc;
                end else begin
                    o_state        = jsu_pkg::STATE_RESET;
                    o_state.phase  = jsu_pkg::PH_BODY;
                    o_res.emit     = 1'b1;
                    o_res.kind     = jsu_pkg::KIND_CP;
                    o_res.cp_value = w_hex_acc;
                end
            end

            default: begin
                // waiting for the opening quote
                o_state = jsu_pkg::STATE_RESET;
                if (i_byte == jsu_pkg::CH_QUOTE) begin
                    o_state.phase = jsu_pkg::PH_BODY;
                end else begin
                    o_res.emit       = 1'b1;
                    o_res.kind       = jsu_pkg::KIND_ERR;
                    o_res.error_code = jsu_pkg::ERR_NO_QUOTE;
                end
            end
        endcase
    end

endmodule

>>> hw/rtl/json_string_unescaper.sv
// Channel    Dir  Interface      Word contents
// ---------  ---  -------------  -----------------------------------------------
// i_byte     in   jsu_byte_if    in_byte: next raw byte of the quoted string
// o_result   out  jsu_result_if  result_kind, cp_value, error_code
//
// One byte word per cycle is taken while i_byte.ready is high; the decoder
// state update is a combinational step between the input register and the
// result register, which holds the result word of an accepted byte.
// Reset (synchronous, active low) empties both registers and returns the
// decoder to waiting for an opening quote.
// A stall on o_result holds the result register; one further byte waits in the
// input register, then i_byte.ready drops until the result is taken.
module json_string_unescaper (
    input  logic                i_clk,
    input  logic                i_rst_n,
    jsu_byte_if.sink            i_byte,
    jsu_result_if.source        o_result
);

    // Input register stage
    logic                       r_in_valid;
    logic [7:0]                 r_in_byte;

    // Decoder state and its next value from the step logic
    jsu_pkg::t_state            r_state;
    jsu_pkg::t_state            n_state;
    jsu_pkg::t_result           w_res;

    // Result register stage
    logic                       r_out_valid;
    logic [1:0]                 r_out_kind;
    logic [jsu_pkg::CP_W-1:0]   r_out_cp;
    logic [2:0]                 r_out_err;

    // Advance the result stage when it is empty or being drained
    logic                       w_adv;
    // Decode the held byte and commit its state update
    logic                       w_step;

    assign w_adv        = !r_out_valid || o_result.ready;
    assign w_step       = r_in_valid && w_adv;
    assign i_byte.ready = !r_in_valid || w_adv;

    jsu_step u_step (
        .i_byte  (r_in_byte),
        .i_state (r_state),
        .o_state (n_state),
        .o_res   (w_res)
    );

    // Control: valid flags and decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= jsu_pkg::STATE_RESET;
        end else begin
            if (i_byte.ready) begin
                r_in_valid <= i_byte.valid;
            end
            if (w_step) begin
                r_state <= n_state;
            end
            if (w_adv) begin
                // bytes that only advance the state leave the result stage empty
                r_out_valid <= w_step && w_res.emit;
            end
        end
    end

    // Payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.in_byte;
        end
        if (w_step && w_res.emit) begin
            r_out_kind <= w_res.kind;
            r_out_cp   <= w_res.cp_value;
            r_out_err  <= w_res.error_code;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.result_kind = r_out_kind;
    assign o_result.cp_value    = r_out_cp;
    assign o_result.error_code  = r_out_err;

    // Only code points carry a value
    a_cp_only_for_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind != jsu_pkg::KIND_CP |-> r_out_cp == '0)
        else $error("cp_value set on a non code point result");

    // Error code present exactly on error results
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_kind == jsu_pkg::KIND_ERR) == (r_out_err != jsu_pkg::ERR_NONE)))
        else $error("error_code does not match result_kind");

    // Any error returns the decoder to waiting with cleared state
    a_err_recover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && w_res.emit && w_res.kind == jsu_pkg::KIND_ERR |=>
        r_state.phase == jsu_pkg::PH_WAIT && r_state.remaining == 2'd0
        && r_state.accumulator == '0)
        else $error("decoder not back to waiting after an error");

    // A pending UTF-8 sequence always has continuation bytes due
    a_utf_remaining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == jsu_pkg::PH_UTF |-> r_state.remaining != 2'd0)
        else $error("UTF-8 phase with no continuation bytes due");

    // A stalled result is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_result.ready |=> r_out_valid && $stable(r_out_kind)
        && $stable(r_out_cp) && $stable(r_out_err))
        else $error("stalled result changed");

endmodule
